/* sv/lcgr_pkg.sv */
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared types and constants for the dual-mode LCG random ranger.
// ----------------------------------------------------------------------------
package lcgr_pkg;

  localparam logic [31:0] LCG_MUL     = 32'h5d58_8b65;
  localparam logic [31:0] LCG_INC_PRI = 32'h0000_0001;
  localparam logic [31:0] LCG_INC_SEC = 32'h0026_9ec3;
  localparam logic [31:0] PCT_SCALE   = 32'd100;

  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_SEED    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RAW     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SCALED  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RANGE   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PERCENT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SECONDARY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_SLOT = 1'd1;

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    K_SEED,
    K_NONE,
    K_RAW,
    K_SCALED,
    K_RANGE,
    K_PERCENT
  } op_kind_t;

  // classified job: arg is seed word or multiplier operand,
  // base is range low bound, direct value or percent threshold
  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] arg;
    logic [31:0] base;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STEP,
    BK_MUL,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic step_en;
    logic mul_en;
    logic fin_load;
  } back_ctrl_t;

endpackage

/* sv/lcgr_front.sv */
// ----------------------------------------------------------------------------
// lcgr_front
// Accepts input words, decodes the action and prepares the operands.
// ----------------------------------------------------------------------------
module lcgr_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcgr_pkg::ACTION_W-1:0] in_action,
  input  logic [31:0]                  in_seed_value,
  input  logic signed [31:0]           in_bound_a,
  input  logic signed [31:0]           in_bound_b,
  input  logic                         q_full,
  output logic                         q_push,
  output lcgr_pkg::job_t               q_job
);
  import lcgr_pkg::*;

  logic [31:0] lo;
  logic [31:0] hi;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (in_bound_a < in_bound_b) begin
      lo = in_bound_a;
      hi = in_bound_b;
    end else begin
      lo = in_bound_b;
      hi = in_bound_a;
    end
  end

  always_comb begin
    q_job.kind = K_NONE;
    q_job.arg  = '0;
    q_job.base = '0;
    case (in_action)
      ACT_SEED: begin
        q_job.kind = K_SEED;
        q_job.arg  = in_seed_value;
      end
      ACT_RAW: begin
        q_job.kind = K_RAW;
      end
      ACT_SCALED: begin
        q_job.kind = K_SCALED;
        q_job.arg  = in_bound_a;
      end
      ACT_RANGE: begin
        // equal bounds: pass the bound through, no draw
        if (in_bound_a == in_bound_b) begin
          q_job.kind = K_NONE;
          q_job.base = in_bound_a;
        end else begin
          q_job.kind = K_RANGE;
          q_job.arg  = hi - lo;
          q_job.base = lo;
        end
      end
      ACT_PERCENT: begin
        q_job.kind = K_PERCENT;
        q_job.arg  = PCT_SCALE;
        q_job.base = in_bound_a;
      end
      default: begin
        q_job.kind = K_NONE;
      end
    endcase
  end

endmodule

/* sv/lcgr_queue.sv */
// ----------------------------------------------------------------------------
// lcgr_queue
// Short FIFO of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module lcgr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcgr_pkg::job_t push_job,
  input  logic           pop,
  output lcgr_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import lcgr_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  job_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CntFull);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* sv/lcgr_back.sv */
// ----------------------------------------------------------------------------
// lcgr_back
// Executes jobs: seeds or advances the generator state, scales the draw and
// loads the result register.
// ----------------------------------------------------------------------------
module lcgr_back #(
  parameter int SECONDARY_SLOTS = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  lcgr_pkg::job_t             q_job,
  output logic                       q_pop,
  input  logic                       use_secondary_mode,
  input  logic [lcgr_pkg::SLOT_W-1:0] secondary_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_value,
  output logic                       out_outcome
);
  import lcgr_pkg::*;

  localparam int IdxW = (SECONDARY_SLOTS > 1) ? $clog2(SECONDARY_SLOTS) : 1;
  localparam logic [SLOT_W:0] SlotLimit = (SLOT_W + 1)'(SECONDARY_SLOTS);
  localparam logic [IdxW-1:0] SlotLast  = IdxW'(SECONDARY_SLOTS - 1);

  back_state_t state_r, state_nxt;
  back_ctrl_t  ctrl;

  job_t        job_r;
  logic [31:0] primary_value_r;
  logic [31:0] primary_draw_count_r;
  logic [31:0] secondary_values_r [SECONDARY_SLOTS];
  logic [15:0] draw_r;
  logic [31:0] prod_r;

  logic              out_valid_r;
  logic signed [31:0] out_value_r;
  logic              out_outcome_r;

  logic [IdxW-1:0] slot_idx;
  logic [31:0]     lcg_cur;
  logic [31:0]     lcg_nxt;
  logic            is_draw;
  logic            out_free;
  logic [31:0]     fin_value;
  logic            fin_outcome;

  assign out_free = !out_valid_r || !out_stall;
  assign is_draw  = (job_r.kind == K_RAW) || (job_r.kind == K_SCALED) ||
                    (job_r.kind == K_RANGE) || (job_r.kind == K_PERCENT);

  // saturate an out-of-range slot to the last one
  always_comb begin
    if ({1'b0, secondary_slot} >= SlotLimit) begin
      slot_idx = SlotLast;
    end else begin
      slot_idx = secondary_slot[IdxW-1:0];
    end
  end

  always_comb begin
    lcg_cur = use_secondary_mode ? secondary_values_r[slot_idx] : primary_value_r;
    lcg_nxt = lcg_cur * LCG_MUL + (use_secondary_mode ? LCG_INC_SEC : LCG_INC_PRI);
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_STEP;
        end
      end
      BK_STEP: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_FIN;
      BK_FIN: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      BK_IDLE: ctrl.pop      = !q_empty;
      BK_STEP: ctrl.step_en  = 1'b1;
      BK_MUL:  ctrl.mul_en   = 1'b1;
      BK_FIN:  ctrl.fin_load = out_free;
      default: ctrl = '0;
    endcase
  end

  assign q_pop = ctrl.pop;

  always_comb begin
    fin_value   = '0;
    fin_outcome = 1'b0;
    case (job_r.kind)
      K_SEED:    fin_value = '0;
      K_NONE:    fin_value = job_r.base;
      K_RAW:     fin_value = {16'd0, draw_r};
      K_SCALED:  fin_value = {16'd0, prod_r[31:16]};
      K_RANGE:   fin_value = job_r.base + {16'd0, prod_r[31:16]};
      K_PERCENT: begin
        fin_value   = {16'd0, prod_r[31:16]};
        fin_outcome = $signed({16'd0, prod_r[31:16]}) < $signed(job_r.base);
      end
      default:   fin_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      job_r <= q_job;
    end
    if (ctrl.mul_en) begin
      prod_r <= {16'd0, draw_r} * job_r.arg;
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_value_r      <= '0;
      primary_draw_count_r <= '0;
      for (int i = 0; i < SECONDARY_SLOTS; i++) begin
        secondary_values_r[i] <= '0;
      end
      draw_r <= '0;
    end else if (ctrl.step_en) begin
      if (job_r.kind == K_SEED) begin
        primary_value_r      <= job_r.arg | 32'd1;
        primary_draw_count_r <= '0;
        for (int i = 0; i < SECONDARY_SLOTS; i++) begin
          secondary_values_r[i] <= job_r.arg;
        end
      end else if (is_draw) begin
        if (use_secondary_mode) begin
          secondary_values_r[slot_idx] <= lcg_nxt;
          draw_r <= lcg_nxt[15:0];
        end else begin
          primary_value_r      <= lcg_nxt;
          primary_draw_count_r <= primary_draw_count_r + 32'd1;
          draw_r <= lcg_nxt[31:16];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin_load) begin
      out_value_r   <= fin_value;
      out_outcome_r <= fin_outcome;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_outcome = out_outcome_r;

endmodule

/* sv/dual_mode_lcg_random_ranger.sv */
// ----------------------------------------------------------------------------
// dual_mode_lcg_random_ranger
// 32-bit LCG random source with raw, scaled, range and percent draws.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. The front end decodes the action
// and precomputes range operands in the accept cycle, then drops the job into
// a two-entry queue, so input words keep being taken while the back end works
// and the queue has room. The back end runs one job at a time through its
// steps (pop, generator step, scale multiply, result load); a stalled result
// register holds the back end in its last step. Configuration is to be written
// by the user via cfg_we/cfg_index/cfg_wdata while idle; no check enforces it.
// ----------------------------------------------------------------------------
module dual_mode_lcg_random_ranger #(
  parameter int SECONDARY_SLOTS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lcgr_pkg::ACTION_W-1:0]  in_action,
  input  logic [31:0]                    in_seed_value,
  input  logic signed [31:0]             in_bound_a,
  input  logic signed [31:0]             in_bound_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_value,
  output logic                           out_outcome,
  input  logic                           cfg_we,
  input  logic [lcgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcgr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lcgr_pkg::*;

  logic              use_secondary_mode_r;
  logic [SLOT_W-1:0] secondary_slot_r;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_secondary_mode_r <= 1'b0;
      secondary_slot_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_SECONDARY:  use_secondary_mode_r <= cfg_wdata[0];
        CFG_SECONDARY_SLOT: secondary_slot_r     <= cfg_wdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  lcgr_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_seed_value (in_seed_value),
    .in_bound_a    (in_bound_a),
    .in_bound_b    (in_bound_b),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  lcgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lcgr_back #(
    .SECONDARY_SLOTS (SECONDARY_SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .use_secondary_mode (use_secondary_mode_r),
    .secondary_slot     (secondary_slot_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_outcome        (out_outcome)
  );

endmodule

/* dv/dual_mode_lcg_random_ranger_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_mode_lcg_random_ranger_tb
// Self-checking bench: a short table of corner words, then bursty random
// traffic over several generator settings. Every result word is compared
// against an in-bench model of both generators and the four draw actions.
// ----------------------------------------------------------------------------
module dual_mode_lcg_random_ranger_tb;
  import lcgr_pkg::*;

  localparam int SLOTS = 5;
  localparam int N_PHASES = 11;
  localparam int WORDS_PER_PHASE = 132;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [31:0]         seed;
    logic [31:0]         bound_a;
    logic [31:0]         bound_b;
    logic                typed;
    logic [31:0]         exp_value;
    logic                exp_outcome;
  } stim_t;

  typedef struct packed {
    logic [31:0] value;
    logic        outcome;
  } draw_result_t;

  // corner words; typed rows carry an expectation readable without the model
  localparam stim_t DIRECTED [25] = '{
    '{ACT_RAW,       32'h0,         32'h0,         32'h0,         1'b1, 32'h0, 1'b0},
    '{ACT_UNUSED_LO, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0, 1'b0},
    '{ACT_UNUSED_HI, 32'h1234_5678, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
    '{ACT_SEED,      32'hffff_ffff, 32'h0,         32'h0,         1'b1, 32'h0, 1'b0},
    '{ACT_RAW,       32'h0,         32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
    '{ACT_SEED,      32'h0,         32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0, 1'b0},
    '{ACT_RAW,       32'h0,         32'h0,         32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_SCALED,    32'h0,         32'h0,         32'h0,         1'b1, 32'h0, 1'b0},
    '{ACT_SCALED,    32'h0,         32'h7fff_ffff, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_SCALED,    32'h0,         32'h8000_0000, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_SCALED,    32'h0,         32'hffff_ffff, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_SCALED,    32'h0,         32'h0001_0000, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_RANGE,     32'h0,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ACT_RANGE,     32'h0,  32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ACT_RANGE,     32'h0,         32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{ACT_RANGE,     32'h0,         32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ACT_RANGE,     32'h0,         32'h0000_0005, 32'hffff_fffd, 1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'h0,         32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'h8000_0000, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'd100,       32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'h7fff_ffff, 32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'd50,        32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_PERCENT,   32'h0,         32'd1,         32'h0,         1'b0, 32'h0, 1'b0},
    '{ACT_SEED,      32'h2468_ace1, 32'h0,         32'h0,         1'b1, 32'h0, 1'b0},
    '{ACT_RAW,       32'h0,         32'h0,         32'h0,         1'b0, 32'h0, 1'b0}
  };

  // {use_secondary_mode, secondary_slot} per random phase; slots 5..7 saturate
  localparam logic [3:0] PHASE_CFG [N_PHASES] = '{
    4'h0, 4'h8, 4'hc, 4'hf, 4'h2, 4'hd, 4'he, 4'h9, 4'hb, 4'h7, 4'ha
  };

  localparam logic [31:0] CORNERS [5] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [ACTION_W-1:0]    in_action;
  logic [31:0]            in_seed_value;
  logic signed [31:0]     in_bound_a;
  logic signed [31:0]     in_bound_b;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [31:0]     out_value;
  logic                   out_outcome;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // generator shadow state and shadow registers
  logic [31:0]            pri_state;
  logic [31:0]            pri_count;
  logic [31:0]            sec_state [SLOTS];
  logic                   sec_mode;
  logic [SLOT_W-1:0]      sec_slot;

  draw_result_t           pending_results [$];
  int                     err_count;
  int                     results_seen;
  int                     burst_left;

  dual_mode_lcg_random_ranger #(
    .SECONDARY_SLOTS(SLOTS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_seed_value(in_seed_value),
    .in_bound_a   (in_bound_a),
    .in_bound_b   (in_bound_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_outcome  (out_outcome),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // advance whichever generator is selected and return its 16-bit draw
  function automatic logic [15:0] lcg_draw();
    int unsigned idx;
    logic [31:0] nxt;
    if (sec_mode) begin
      idx = (sec_slot >= SLOTS) ? SLOTS - 1 : sec_slot;
      nxt = sec_state[idx] * LCG_MUL + LCG_INC_SEC;
      sec_state[idx] = nxt;
      return nxt[15:0];
    end
    pri_count = pri_count + 32'd1;
    pri_state = pri_state * LCG_MUL + LCG_INC_PRI;
    return pri_state[31:16];
  endfunction

  function automatic draw_result_t predict_draw(input logic [ACTION_W-1:0] act,
                                                input logic [31:0] seed,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    draw_result_t res;
    logic [31:0] r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] prod;
    res = '0;
    case (act)
      ACT_SEED: begin
        pri_state = seed | 32'h1;
        pri_count = 32'd0;
        for (int i = 0; i < SLOTS; i++) sec_state[i] = seed;
      end
      ACT_RAW: begin
        res.value = {16'h0, lcg_draw()};
      end
      ACT_SCALED: begin
        r = {16'h0, lcg_draw()};
        prod = r * a;
        res.value = {16'h0, prod[31:16]};
      end
      ACT_RANGE: begin
        if (a == b) begin
          res.value = a;
        end else begin
          if (a < b) begin
            lo = a;
            hi = b;
          end else begin
            lo = b;
            hi = a;
          end
          r = {16'h0, lcg_draw()};
          prod = r * (hi - lo);
          res.value = lo + {16'h0, prod[31:16]};
        end
      end
      ACT_PERCENT: begin
        r = {16'h0, lcg_draw()};
        prod = r * PCT_SCALE;
        res.value = prod >> 16;
        res.outcome = ($signed(res.value) < a);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_t random_word();
    stim_t w;
    int unsigned pick;
    w = '0;
    w.seed = $urandom;
    w.bound_a = $urandom;
    w.bound_b = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) w.action = ACT_SEED;
    else if (pick < 8) w.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    else if (pick < 30) w.action = ACT_RAW;
    else if (pick < 52) w.action = ACT_SCALED;
    else if (pick < 76) w.action = ACT_RANGE;
    else w.action = ACT_PERCENT;
    case ($urandom_range(0, 3))
      1: begin
        // small signed bounds, around the percent window
        w.bound_a = $urandom_range(0, 230) - 115;
        w.bound_b = $urandom_range(0, 230) - 115;
      end
      2: begin
        w.bound_a = CORNERS[$urandom_range(0, 4)];
        w.bound_b = CORNERS[$urandom_range(0, 4)];
      end
      3: w.bound_b = w.bound_a;
      default: ;
    endcase
    return w;
  endfunction

  // hold the word until taken, then log its expected result
  task automatic offer_word(input stim_t w);
    draw_result_t exp_res;
    in_valid      <= 1'b1;
    in_action     <= w.action;
    in_seed_value <= w.seed;
    in_bound_a    <= w.bound_a;
    in_bound_b    <= w.bound_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = predict_draw(w.action, w.seed, w.bound_a, w.bound_b);
    if (w.typed) begin
      exp_res.value = w.exp_value;
      exp_res.outcome = w.exp_outcome;
    end
    pending_results.push_back(exp_res);
  endtask

  // burst pacing: drop valid for a random gap once the burst runs out
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input logic mode, input logic [SLOT_W-1:0] slot);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_USE_SECONDARY;
    cfg_wdata <= {2'($urandom_range(0, 3)), mode};
    @(posedge clk);
    cfg_index <= CFG_SECONDARY_SLOT;
    cfg_wdata <= slot;
    @(posedge clk);
    cfg_we <= 1'b0;
    sec_mode = mode;
    sec_slot = slot;
  endtask

  initial begin
    stim_t w;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_SEED;
    in_seed_value <= 32'h0;
    in_bound_a    <= 32'h0;
    in_bound_b    <= 32'h0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_USE_SECONDARY;
    cfg_wdata     <= '0;
    pri_state = 32'h0;
    pri_count = 32'h0;
    for (int i = 0; i < SLOTS; i++) sec_state[i] = 32'h0;
    sec_mode = 1'b0;
    sec_slot = '0;
    err_count = 0;
    results_seen = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      offer_word(DIRECTED[i]);
      if (i != 24) pace_sender();
    end
    in_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < N_PHASES; p++) begin
      write_config(PHASE_CFG[p][3], PHASE_CFG[p][2:0]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w = random_word();
        offer_word(w);
        if (n != WORDS_PER_PHASE - 1) pace_sender();
      end
      in_valid <= 1'b0;
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: stall patterns of its own, plus one long hold-off to back up the block
  initial begin
    int pattern;
    int left;
    int hold;
    logic stall_next;
    bit pressed;
    pattern = 0;
    left = 0;
    pressed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!pressed && results_seen >= 400) begin
        pressed = 1'b1;
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 150) begin
          @(posedge clk);
          hold++;
        end
      end else begin
        if (left == 0) begin
          pattern = $urandom_range(0, 3);
          left = $urandom_range(20, 80);
        end
        left--;
        case (pattern)
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          3: stall_next = ~out_stall;
          default: stall_next = 1'b0;
        endcase
        out_stall <= stall_next;
      end
    end
  end

  always @(posedge clk) begin : check_results
    draw_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: value %h outcome %b", out_value, out_outcome);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $error("value: expected %h actual %h", exp_res.value, out_value);
          err_count++;
        end
        if (out_outcome !== exp_res.outcome) begin
          $error("outcome: expected %b actual %b", exp_res.outcome, out_outcome);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
